// ===== rtl/core/brf_pkg.sv =====
// package for the byte ring fifo with peek
// shared types, codes and defaults; no dependencies
`default_nettype none

package brf_pkg;

  // default number of storage cells in the chain
  localparam int MAX_DEPTH_DEF = 256;

  // field widths
  localparam int DATA_W  = 8;
  localparam int COUNT_W = 9;
  localparam int MODE_W  = 2;
  localparam int POS_W   = 8;

  // capacity register after reset
  localparam logic [COUNT_W-1:0] CAP_RESET = 9'd256;

  // register word index on the config port
  localparam logic REG_CAPACITY = 1'b0;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_PEEK   = 2'd2
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // operation token that walks the cell chain
  typedef struct packed {
    logic               valid;
    logic               wr;
    logic               rd;
    logic [DATA_W-1:0]  data;
    status_t            status;
    logic [COUNT_W-1:0] fill_count;
    logic               is_full;
    logic               is_empty;
  } brf_tok_t;

endpackage

`default_nettype wire

// ===== rtl/core/brf_req_if.sv =====
// request channel of the byte ring fifo: one operation per beat
// depends on brf_pkg for field widths
`default_nettype none

interface brf_req_if;
  logic                        valid;
  logic                        ready;
  logic [brf_pkg::MODE_W-1:0]  mode;
  logic [brf_pkg::DATA_W-1:0]  value;
  logic [brf_pkg::POS_W-1:0]   position;

  modport source (output valid, mode, value, position, input ready);
  modport sink   (input valid, mode, value, position, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/brf_rsp_if.sv =====
// response channel of the byte ring fifo: one result per beat
// depends on brf_pkg for field widths
`default_nettype none

interface brf_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [brf_pkg::DATA_W-1:0]   peek_data;
  logic [brf_pkg::COUNT_W-1:0]  fill_count;
  logic                         is_full;
  logic                         is_empty;

  modport source (output valid, status, peek_data, fill_count, is_full, is_empty,
                  input ready);
  modport sink   (input valid, status, peek_data, fill_count, is_full, is_empty,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/brf_ctrl.sv =====
// head of the chain: ring pointers, fill count and capacity register
// turns each accepted operation into a token and a target slot; uses brf_pkg
`default_nettype none

module brf_ctrl #(
  parameter int MAX_DEPTH = brf_pkg::MAX_DEPTH_DEF,
  parameter int SW        = $clog2(MAX_DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [brf_pkg::MODE_W-1:0]  mode,
  input  wire logic [brf_pkg::DATA_W-1:0]  value,
  input  wire logic [brf_pkg::POS_W-1:0]   position,
  input  wire logic                        cfg_we,
  input  wire logic [brf_pkg::COUNT_W-1:0] cfg_data,
  output brf_pkg::brf_tok_t                tok,
  output logic [SW-1:0]                    slot,
  output logic [brf_pkg::COUNT_W-1:0]      capacity
);
  import brf_pkg::*;

  // width that holds both the capacity register and the depth
  localparam int EW = ($clog2(MAX_DEPTH + 1) > COUNT_W) ? $clog2(MAX_DEPTH + 1) : COUNT_W;

  logic [SW-1:0]      rd_idx;
  logic [SW-1:0]      rd_idx_next;
  logic [SW-1:0]      wr_idx;
  logic [SW-1:0]      wr_idx_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [EW-1:0]      cap_eff;
  logic [EW:0]        wr_inc;
  logic [EW:0]        rd_inc;
  logic [EW:0]        peek_sum;
  logic [EW:0]        peek_slot;

  // capacity clamped to 1..MAX_DEPTH
  always_comb begin
    if (capacity == '0) begin
      cap_eff = EW'(1);
    end else if (EW'(capacity) > EW'(MAX_DEPTH)) begin
      cap_eff = EW'(MAX_DEPTH);
    end else begin
      cap_eff = EW'(capacity);
    end
  end

  // pointer increments and peek slot with a single wrap
  assign wr_inc    = (EW + 1)'(wr_idx) + (EW + 1)'(1);
  assign rd_inc    = (EW + 1)'(rd_idx) + (EW + 1)'(1);
  assign peek_sum  = (EW + 1)'(rd_idx) + (EW + 1)'(position);
  assign peek_slot = (peek_sum >= {1'b0, cap_eff}) ? (peek_sum - {1'b0, cap_eff}) : peek_sum;

  // operation decode and token build
  always_comb begin
    rd_idx_next    = rd_idx;
    wr_idx_next    = wr_idx;
    count_next     = count;
    slot           = '0;
    tok.valid      = accept;
    tok.wr         = 1'b0;
    tok.rd         = 1'b0;
    tok.data       = '0;
    tok.status     = ST_OK;
    case (mode)
      MODE_ADD: begin
        if (EW'(count) >= cap_eff) begin
          tok.status = ST_FULL;
        end else begin
          tok.wr      = 1'b1;
          tok.data    = value;
          slot        = wr_idx;
          wr_idx_next = (wr_inc >= {1'b0, cap_eff}) ? '0 : wr_inc[SW-1:0];
          count_next  = count + COUNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        if (count == '0) begin
          tok.status = ST_EMPTY;
        end else begin
          rd_idx_next = (rd_inc >= {1'b0, cap_eff}) ? '0 : rd_inc[SW-1:0];
          count_next  = count - COUNT_W'(1);
        end
      end
      MODE_PEEK: begin
        if (EW'(position) > cap_eff) begin
          tok.status = ST_RANGE;
        end else if (COUNT_W'(position) >= count) begin
          tok.status = ST_EMPTY;
        end else begin
          tok.rd = 1'b1;
          slot   = peek_slot[SW-1:0];
        end
      end
      default: begin
        tok.status = ST_OK;
      end
    endcase
    tok.fill_count = count_next;
    tok.is_full    = (EW'(count_next) == cap_eff);
    tok.is_empty   = (count_next == '0);
  end

  // pointer, count and capacity registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      wr_idx   <= '0;
      count    <= '0;
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      rd_idx   <= '0;
      wr_idx   <= '0;
      count    <= '0;
      capacity <= cfg_data;
    end else if (accept) begin
      rd_idx <= rd_idx_next;
      wr_idx <= wr_idx_next;
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/brf_cell.sv =====
// one storage cell of the chain: holds the byte of its slot
// and passes the operation token on to the next cell; uses brf_pkg
`default_nettype none

module brf_cell #(
  parameter int SW  = 8,
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire brf_pkg::brf_tok_t tok_in,
  input  wire logic [SW-1:0]     slot_in,
  output brf_pkg::brf_tok_t      tok_out,
  output logic [SW-1:0]          slot_out
);
  import brf_pkg::*;

  logic [DATA_W-1:0] slot_byte;
  logic              hit;
  brf_tok_t          tok_next;

  assign hit = tok_in.valid && (slot_in == SW'(IDX));

  // stored byte of this slot
  always_ff @(posedge clk) begin
    if (adv && hit && tok_in.wr) begin
      slot_byte <= tok_in.data;
    end
  end

  // token payload, picking up the byte on a peek of this slot
  always_comb begin
    tok_next = tok_in;
    if (hit && tok_in.rd) begin
      tok_next.data = slot_byte;
    end
  end

  // token stage towards the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (adv) begin
      tok_out  <= tok_next;
      slot_out <= slot_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/byte_ring_fifo_with_peek.sv =====
// top level of the byte ring fifo with peek
// depends on brf_pkg, brf_req_if, brf_rsp_if, brf_ctrl and brf_cell
`default_nettype none

// Byte ring FIFO with add, remove and peek. The head decides each operation
// at once (pointers, count, status) and sends a token down a chain of
// MAX_DEPTH cells, one cell per slot; the cell of the target slot stores the
// byte of an add or hands its byte to a peek. One operation is taken every
// cycle unless the chain holds; results leave the last cell in order. While a
// result waits at the output the whole chain holds and the request side is
// not ready. Writing the capacity register empties the ring; the stored
// bytes stay but are no longer reachable.
module byte_ring_fifo_with_peek #(
  parameter int MAX_DEPTH = brf_pkg::MAX_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  brf_req_if.sink          req,
  brf_rsp_if.source        rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import brf_pkg::*;

  localparam int SW = $clog2(MAX_DEPTH);

  brf_tok_t           tok [0:MAX_DEPTH];
  logic [SW-1:0]      slot [0:MAX_DEPTH];
  logic               adv;
  logic               accept;
  logic               cfg_we;
  logic [COUNT_W-1:0] capacity;

  // chain moves whenever the output stage is free or being drained
  assign adv        = !tok[MAX_DEPTH].valid || rsp.ready;
  assign req.ready  = adv;
  assign accept     = req.valid && adv;

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity) : '0;

  brf_ctrl #(
    .MAX_DEPTH (MAX_DEPTH),
    .SW        (SW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .mode     (req.mode),
    .value    (req.value),
    .position (req.position),
    .cfg_we   (cfg_we),
    .cfg_data (pwdata[COUNT_W-1:0]),
    .tok      (tok[0]),
    .slot     (slot[0]),
    .capacity (capacity)
  );

  // row of storage cells
  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    brf_cell #(
      .SW  (SW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .tok_in   (tok[i]),
      .slot_in  (slot[i]),
      .tok_out  (tok[i+1]),
      .slot_out (slot[i+1])
    );
  end

  // result beat from the last cell
  assign rsp.valid      = tok[MAX_DEPTH].valid;
  assign rsp.status     = tok[MAX_DEPTH].status;
  assign rsp.peek_data  = tok[MAX_DEPTH].rd ? tok[MAX_DEPTH].data : '0;
  assign rsp.fill_count = tok[MAX_DEPTH].fill_count;
  assign rsp.is_full    = tok[MAX_DEPTH].is_full;
  assign rsp.is_empty   = tok[MAX_DEPTH].is_empty;

endmodule

`default_nettype wire

// ===== rtl/core/brf_chk.sv =====
// port checker for the byte ring fifo with peek, bound to the top level
// depends on brf_pkg for status codes
`default_nettype none

module brf_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [1:0] status,
  input wire logic [7:0] peek_data,
  input wire logic [8:0] fill_count,
  input wire logic       is_full,
  input wire logic       is_empty
);
  import brf_pkg::*;

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(peek_data)
      && $stable(fill_count))
    else $error("result beat changed while stalled");

  // capacity is at least one, so never full and empty together
  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(is_full && is_empty))
    else $error("full and empty both set");

  // empty flag follows the count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (fill_count == '0)))
    else $error("empty flag disagrees with count");

  // a refused add leaves the ring full
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL) |-> is_full)
    else $error("full status without full flag");

  // only a good peek carries data
  a_peek: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) |-> (peek_data == '0))
    else $error("peek data on a failed operation");

endmodule

bind byte_ring_fifo_with_peek brf_chk u_brf_chk (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .peek_data  (rsp.peek_data),
  .fill_count (rsp.fill_count),
  .is_full    (rsp.is_full),
  .is_empty   (rsp.is_empty)
);

`default_nettype wire
